[rtl/core/stl_pkg.sv]
// Shared types, constants and character-class functions for the source token lexer.
package stl_pkg;

  parameter int POS_BITS = 24;
  localparam int OUT_POS_BITS = 24;
  localparam int KIND_BITS = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int OP_IDX_BITS = 3;

  typedef logic [POS_BITS-1:0] pos_t;

  // Operation carried on the input tuser
  typedef enum logic {
    OPER_BYTE = 1'b0,
    OPER_EOS  = 1'b1
  } oper_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_EOF      = 6'd0,
    K_ERROR    = 6'd1,
    K_IDENT    = 6'd2,
    K_NUMBER   = 6'd3,
    K_STRING   = 6'd4,
    K_SEMI     = 6'd5,
    K_DOT      = 6'd6,
    K_DOLLAR   = 6'd7,
    K_COMMA    = 6'd8,
    K_BANG     = 6'd9,
    K_QUEST    = 6'd10,
    K_AT       = 6'd11,
    K_HASH     = 6'd12,
    K_AMP      = 6'd13,
    K_LPAREN   = 6'd14,
    K_RPAREN   = 6'd15,
    K_LBRACE   = 6'd16,
    K_RBRACE   = 6'd17,
    K_LBRACKET = 6'd18,
    K_RBRACKET = 6'd19,
    K_LT       = 6'd20,
    K_SHL      = 6'd21,
    K_LE       = 6'd22,
    K_GT       = 6'd23,
    K_SHR      = 6'd24,
    K_GE       = 6'd25,
    K_PLUS     = 6'd26,
    K_INC      = 6'd27,
    K_ADD_EQ   = 6'd28,
    K_MINUS    = 6'd29,
    K_DEC      = 6'd30,
    K_SUB_EQ   = 6'd31,
    K_STAR     = 6'd32,
    K_MUL_EQ   = 6'd33,
    K_SLASH    = 6'd34,
    K_DSLASH   = 6'd35,
    K_DIV_EQ   = 6'd36,
    K_ASSIGN   = 6'd37,
    K_EQ       = 6'd38,
    K_ARROW    = 6'd39,
    K_COLON    = 6'd40,
    K_DCOLON   = 6'd41,
    K_DEF_EQ   = 6'd42
  } kind_t;

  typedef struct packed {
    kind_t kind;
    pos_t  start_pos;
    pos_t  end_pos;
    logic  last;
  } tok_t;

  // Up to two tokens produced by one item; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } push_t;

  typedef struct packed {
    kind_t      single;
    logic [7:0] c1;
    kind_t      k1;
    logic [7:0] c2;
    kind_t      k2;
  } op_rule_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h09;
  endfunction

  // Operator lead characters, in state order: = : + - * / < >
  function automatic logic [OP_IDX_BITS:0] op_lookup(input logic [7:0] c);
    logic [OP_IDX_BITS:0] r;
    unique case (c)
      8'h3D:   r = {1'b1, 3'd0};
      8'h3A:   r = {1'b1, 3'd1};
      8'h2B:   r = {1'b1, 3'd2};
      8'h2D:   r = {1'b1, 3'd3};
      8'h2A:   r = {1'b1, 3'd4};
      8'h2F:   r = {1'b1, 3'd5};
      8'h3C:   r = {1'b1, 3'd6};
      8'h3E:   r = {1'b1, 3'd7};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic op_rule_t op_rule(input logic [OP_IDX_BITS-1:0] idx);
    op_rule_t r;
    unique case (idx)
      3'd0:    r = '{K_ASSIGN, 8'h3E, K_ARROW,  8'h3D, K_EQ};
      3'd1:    r = '{K_COLON,  8'h3A, K_DCOLON, 8'h3D, K_DEF_EQ};
      3'd2:    r = '{K_PLUS,   8'h2B, K_INC,    8'h3D, K_ADD_EQ};
      3'd3:    r = '{K_MINUS,  8'h2D, K_DEC,    8'h3D, K_SUB_EQ};
      3'd4:    r = '{K_STAR,   8'h3D, K_MUL_EQ, 8'h3D, K_MUL_EQ};
      3'd5:    r = '{K_SLASH,  8'h2F, K_DSLASH, 8'h3D, K_DIV_EQ};
      3'd6:    r = '{K_LT,     8'h3C, K_SHL,    8'h3D, K_LE};
      default: r = '{K_GT,     8'h3E, K_SHR,    8'h3D, K_GE};
    endcase
    return r;
  endfunction

  // Single-character punctuation; returns {hit, kind}
  function automatic logic [KIND_BITS:0] punct_lookup(input logic [7:0] c);
    logic [KIND_BITS:0] r;
    unique case (c)
      8'h3B:   r = {1'b1, K_SEMI};
      8'h2E:   r = {1'b1, K_DOT};
      8'h24:   r = {1'b1, K_DOLLAR};
      8'h2C:   r = {1'b1, K_COMMA};
      8'h21:   r = {1'b1, K_BANG};
      8'h3F:   r = {1'b1, K_QUEST};
      8'h40:   r = {1'b1, K_AT};
      8'h23:   r = {1'b1, K_HASH};
      8'h26:   r = {1'b1, K_AMP};
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h7B:   r = {1'b1, K_LBRACE};
      8'h7D:   r = {1'b1, K_RBRACE};
      8'h5B:   r = {1'b1, K_LBRACKET};
      8'h5D:   r = {1'b1, K_RBRACKET};
      default: r = {1'b0, K_ERROR};
    endcase
    return r;
  endfunction

  // Fit an internal position to the output field width
  function automatic logic [OUT_POS_BITS-1:0] to_out_pos(input pos_t p);
    logic [POS_BITS+OUT_POS_BITS-1:0] ext;
    ext = {{OUT_POS_BITS{1'b0}}, p};
    return ext[OUT_POS_BITS-1:0];
  endfunction

endpackage

[rtl/core/stl_lex_core.sv]
// Lexer state registers and the per-item next-state and token logic.
module stl_lex_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  logic             item_oper,
  input  logic [7:0]       item_byte,
  output stl_pkg::push_t   push
);
  import stl_pkg::*;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_IDENT    = 4'd1,
    ST_NUM      = 4'd2,
    ST_STR      = 4'd3,
    ST_OP_EQ    = 4'd4,
    ST_OP_COLON = 4'd5,
    ST_OP_PLUS  = 4'd6,
    ST_OP_MINUS = 4'd7,
    ST_OP_STAR  = 4'd8,
    ST_OP_SLASH = 4'd9,
    ST_OP_LT    = 4'd10,
    ST_OP_GT    = 4'd11
  } lex_state_t;

  localparam pos_t POS_MAX = '1;

  lex_state_t state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       ts_r, ts_nxt;
  logic       fin_r, fin_nxt;

  pos_t       pos_inc;

  // Start-state decode of the current byte
  logic       lfs_emit;
  tok_t       lfs_tok;
  lex_state_t lfs_state;
  logic       lfs_set_ts;
  logic       lfs_inc;
  logic       lfs_fin;

  push_t      push_c;

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  always_comb begin
    logic [OP_IDX_BITS:0] opl;
    logic [KIND_BITS:0]   pl;
    opl        = op_lookup(item_byte);
    pl         = punct_lookup(item_byte);
    lfs_emit   = 1'b0;
    lfs_tok    = '{K_ERROR, pos_r, pos_inc, 1'b0};
    lfs_state  = ST_START;
    lfs_set_ts = 1'b0;
    lfs_inc    = 1'b1;
    lfs_fin    = 1'b0;
    priority if (item_byte == 8'h00) begin
      lfs_emit = 1'b1;
      lfs_tok  = '{K_EOF, pos_r, pos_r, 1'b0};
      lfs_inc  = 1'b0;
      lfs_fin  = 1'b1;
    end else if (is_space(item_byte)) begin
      lfs_emit = 1'b0;
    end else if (is_alpha(item_byte)) begin
      lfs_state  = ST_IDENT;
      lfs_set_ts = 1'b1;
    end else if (is_digit(item_byte)) begin
      lfs_state  = ST_NUM;
      lfs_set_ts = 1'b1;
    end else if (item_byte == 8'h22) begin
      lfs_state  = ST_STR;
      lfs_set_ts = 1'b1;
    end else if (opl[OP_IDX_BITS]) begin
      lfs_state  = lex_state_t'(4'(ST_OP_EQ) + {1'b0, opl[OP_IDX_BITS-1:0]});
      lfs_set_ts = 1'b1;
    end else if (pl[KIND_BITS]) begin
      lfs_emit = 1'b1;
      lfs_tok  = '{kind_t'(pl[KIND_BITS-1:0]), pos_r, pos_inc, 1'b0};
    end else begin
      lfs_emit = 1'b1;
    end
  end

  always_comb begin
    logic                   pend_v;
    kind_t                  pend_k;
    op_rule_t               rule;
    logic [OP_IDX_BITS-1:0] oidx;
    logic [3:0]             odiff;
    odiff     = 4'(state_r) - 4'(ST_OP_EQ);
    oidx      = odiff[OP_IDX_BITS-1:0];
    rule      = op_rule(oidx);
    pend_v    = 1'b0;
    pend_k    = K_ERROR;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    ts_nxt    = ts_r;
    fin_nxt   = fin_r;
    push_c    = '0;

    if (fin_r) begin
      // drop everything once Eof has gone out
      push_c = '0;
    end else if (item_oper == OPER_EOS) begin
      unique case (state_r)
        ST_IDENT: begin pend_v = 1'b1; pend_k = K_IDENT;     end
        ST_NUM:   begin pend_v = 1'b1; pend_k = K_NUMBER;    end
        ST_STR:   begin pend_v = 1'b1; pend_k = K_ERROR;     end
        ST_OP_EQ, ST_OP_COLON, ST_OP_PLUS, ST_OP_MINUS,
        ST_OP_STAR, ST_OP_SLASH, ST_OP_LT, ST_OP_GT: begin
          pend_v = 1'b1;
          pend_k = rule.single;
        end
        default:  begin pend_v = 1'b0; pend_k = K_ERROR;     end
      endcase
      if (pend_v) begin
        push_c.v0 = 1'b1;
        push_c.t0 = '{pend_k, ts_r, pos_r, 1'b0};
        push_c.v1 = 1'b1;
        push_c.t1 = '{K_EOF, pos_r, pos_r, 1'b0};
      end else begin
        push_c.v0 = 1'b1;
        push_c.t0 = '{K_EOF, pos_r, pos_r, 1'b0};
      end
      state_nxt = ST_START;
      fin_nxt   = 1'b1;
    end else begin
      unique case (state_r)
        ST_IDENT, ST_NUM: begin
          if (is_digit(item_byte) || (state_r == ST_IDENT && is_alpha(item_byte))) begin
            pos_nxt = pos_inc;
          end else begin
            push_c.v0 = 1'b1;
            push_c.t0 = '{(state_r == ST_IDENT) ? K_IDENT : K_NUMBER, ts_r, pos_r, 1'b0};
            push_c.v1 = lfs_emit;
            push_c.t1 = lfs_tok;
            state_nxt = lfs_state;
            if (lfs_set_ts) ts_nxt = pos_r;
            if (lfs_inc) pos_nxt = pos_inc;
            fin_nxt = lfs_fin;
          end
        end
        ST_STR: begin
          pos_nxt = pos_inc;
          if (item_byte == 8'h22) begin
            push_c.v0 = 1'b1;
            push_c.t0 = '{K_STRING, ts_r, pos_inc, 1'b0};
            state_nxt = ST_START;
          end
        end
        ST_OP_EQ, ST_OP_COLON, ST_OP_PLUS, ST_OP_MINUS,
        ST_OP_STAR, ST_OP_SLASH, ST_OP_LT, ST_OP_GT: begin
          if (item_byte == rule.c1 || item_byte == rule.c2) begin
            pos_nxt   = pos_inc;
            push_c.v0 = 1'b1;
            push_c.t0 = '{(item_byte == rule.c1) ? rule.k1 : rule.k2, ts_r, pos_inc, 1'b0};
            state_nxt = ST_START;
          end else begin
            push_c.v0 = 1'b1;
            push_c.t0 = '{rule.single, ts_r, pos_r, 1'b0};
            push_c.v1 = lfs_emit;
            push_c.t1 = lfs_tok;
            state_nxt = lfs_state;
            if (lfs_set_ts) ts_nxt = pos_r;
            if (lfs_inc) pos_nxt = pos_inc;
            fin_nxt = lfs_fin;
          end
        end
        default: begin
          push_c.v0 = lfs_emit;
          push_c.t0 = lfs_tok;
          state_nxt = lfs_state;
          if (lfs_set_ts) ts_nxt = pos_r;
          if (lfs_inc) pos_nxt = pos_inc;
          fin_nxt = lfs_fin;
        end
      endcase
    end

    push_c.t0.last = !push_c.v1;
    push_c.t1.last = 1'b1;
    push_c.v0      = push_c.v0 & item_vld;
    push_c.v1      = push_c.v1 & item_vld;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      pos_r   <= '0;
      ts_r    <= '0;
      fin_r   <= 1'b0;
    end else if (item_vld) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ts_r    <= ts_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second token without first");

  a_silent_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && item_vld) |-> !push.v0)
    else $error("token after Eof");

  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld |=> pos_r >= $past(pos_r))
    else $error("position went backward");

endmodule

[rtl/core/stl_out_fifo.sv]
// Small result queue that takes up to two tokens per cycle and hands out one.
module stl_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  stl_pkg::push_t push,
  output logic           room,
  output logic           deq_vld,
  input  logic           deq_rdy,
  output stl_pkg::tok_t  deq_tok
);
  import stl_pkg::*;

  typedef logic [FIFO_AW-1:0] ptr_t;
  typedef logic [FIFO_CW-1:0] cnt_t;

  tok_t mem_r [FIFO_DEPTH];
  ptr_t wr_r, wr_nxt;
  ptr_t rd_r, rd_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic pop;
  ptr_t wr_p1;

  assign pop     = deq_vld && deq_rdy;
  assign deq_vld = (cnt_r != '0);
  assign deq_tok = mem_r[rd_r];
  // two free slots guarantee a full item fits even without a pop
  assign room    = (cnt_r <= cnt_t'(FIFO_DEPTH - 2));
  assign wr_p1   = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + ptr_t'(push.v0) + ptr_t'(push.v1);
    rd_nxt  = rd_r + ptr_t'(pop);
    cnt_nxt = cnt_r + cnt_t'(push.v0) + cnt_t'(push.v1) - cnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_r] <= push.t0;
    if (push.v1) mem_r[wr_p1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

[rtl/core/source_token_lexer.sv]
// Top level of the streaming source token lexer.
//
// Usage:
//   Input channel in_*: one item per source byte. in_tdata[7:0] is the byte,
//   in_tuser is the operation (0 = source byte, 1 = end of source).
//   Result channel out_*: one item per token. out_tdata holds the token kind,
//   start position and end position; out_tlast marks the last token caused by
//   a given input item (an item causes zero, one or two tokens).
//   An accepted item is held in the input register until the result queue has
//   room; its tokens are then written into the queue, which raises out_tvalid.
//   Throughput: one item per cycle while tokens drain as fast as they appear.
//   The input register advances only while the four-entry result queue has
//   two free slots, so an item giving two tokens still fits, and a stalled
//   receiver backs up to in_tready without losing or repeating anything.
//   Reset (rst_n low, synchronous) empties the queue and the input register,
//   returns the lexer to the start state with position zero. After Eof has
//   been emitted (NUL byte or end of source) every further item is taken and
//   dropped until the next reset.
module source_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [5:0] token_kind, [29:6] start_pos, [53:30] end_pos
  output logic        out_tlast   // last_of_item
);
  import stl_pkg::*;

  // Input register: holds one item until the core can take it
  logic       in_vld_r;
  logic       in_oper_r;
  logic [7:0] in_byte_r;

  logic       advance;
  logic       room;
  push_t      push;
  tok_t       deq_tok;

  // Advance the held item into the core when the queue can absorb two tokens
  assign advance   = in_vld_r && room;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // Payload needs no reset: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_oper_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  stl_lex_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (advance),
    .item_oper (in_oper_r),
    .item_byte (in_byte_r),
    .push      (push)
  );

  stl_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .deq_vld (out_tvalid),
    .deq_rdy (out_tready),
    .deq_tok (deq_tok)
  );

  // Pack the head token onto the result bus, zero-filled to whole bytes
  assign out_tdata = {2'b00, to_out_pos(deq_tok.end_pos), to_out_pos(deq_tok.start_pos),
                      deq_tok.kind};
  assign out_tlast = deq_tok.last;

endmodule
